// ----- hw/rtl/pfe_pkg.sv -----
// Package for the palette fade engine: command codes, state encoding and fade constants.
// No dependencies; imported by palette_fade_engine.
package pfe_pkg;

    // Default palette size in colors
    localparam int unsigned MAX_COLORS_DEF = 256;

    // Fixed field widths
    localparam int unsigned ENTRY_W  = 10;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned REMAIN_W = 10;
    localparam int unsigned CCOUNT_W = 9;
    localparam int unsigned SPEED_W  = 5;
    localparam int unsigned SRC_W    = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    // Command codes
    localparam logic [1:0] MODE_WR_CUR = 2'd0;
    localparam logic [1:0] MODE_WR_TGT = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_RD_CUR = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT   = 2'd2;

    // Fade target sources (anything else uses the stored target palette)
    localparam logic [SRC_W-1:0] SRC_BLACK = 2'd0;
    localparam logic [SRC_W-1:0] SRC_WHITE = 2'd1;

    // Fade step constants
    localparam logic [DATA_W-1:0]  STEP_UNIT   = 32'h0080_0000;
    localparam logic [DATA_W-1:0]  WHITE_LEVEL = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0]  BLACK_LEVEL = 32'h0000_0000;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 5'd30;

    // Reset values of the configuration registers
    localparam logic [SRC_W-1:0]    TARGET_SOURCE_RST = 2'd0;
    localparam logic [SPEED_W-1:0]  SPEED_RST         = 5'd0;
    localparam logic [CCOUNT_W-1:0] COLOR_COUNT_RST   = 9'd256;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_TICK
    } state_t;

endpackage

// ----- hw/rtl/palette_fade_engine.sv -----
// Palette fade engine: current/target palette memories and the fade sweep sequencer.
// Depends on pfe_pkg.
// Results: a write gives its result strobe in the cycle after start, a read after the
// ST_READ state, a fade tick at the end of the ST_TICK sweep (one component per cycle through the
// one-read, one-write current palette memory). busy stays high while a read or tick runs;
// a write keeps busy low so the next command can start in the following cycle.
// Results cannot be stalled. Reset clears the sequencer, loads the config reset values and
// sets the unfinished count to the full palette; palette memories hold garbage until written.
module palette_fade_engine
    import pfe_pkg::*;
#(
    parameter int unsigned MAX_COLORS = MAX_COLORS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            mode,
    input  logic [ENTRY_W-1:0]    entry,
    input  logic [DATA_W-1:0]     value,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // result channel
    output logic                  result_valid,
    output logic [DATA_W-1:0]     read_value,
    output logic [REMAIN_W-1:0]   remaining,
    output logic                  done_res
);

    localparam int unsigned NCOMP = MAX_COLORS * 3;
    localparam int unsigned AW    = $clog2(NCOMP);
    localparam int unsigned NCW   = $clog2(NCOMP + 1);
    localparam int unsigned CCW   = $clog2(MAX_COLORS + 1);

    // Configuration registers
    logic [SRC_W-1:0]    target_source_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [CCOUNT_W-1:0] color_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_source_reg <= TARGET_SOURCE_RST;
            speed_reg         <= SPEED_RST;
            color_count_reg   <= COLOR_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_SOURCE: target_source_reg <= cfg_data[SRC_W-1:0];
                CFG_SPEED:         speed_reg         <= cfg_data[SPEED_W-1:0];
                CFG_COLOR_COUNT:   color_count_reg   <= cfg_data[CCOUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Active component count: colors clamped to 1..MAX_COLORS, three channels each
    logic [CCW-1:0] colors_clamped;
    logic [NCW-1:0] n_comp;

    always_comb
    begin
        priority if (color_count_reg == '0)
            colors_clamped = CCW'(1);
        else if (32'(color_count_reg) > MAX_COLORS)
            colors_clamped = CCW'(MAX_COLORS);
        else
            colors_clamped = CCW'(color_count_reg);
    end

    assign n_comp = NCW'(colors_clamped) * NCW'(3);

    // Fade step: speed saturated at its maximum, half a unit at zero
    logic [SPEED_W-1:0] speed_sat;
    logic [DATA_W-1:0]  step;

    assign speed_sat = (speed_reg > SPEED_MAX) ? SPEED_MAX : speed_reg;
    assign step      = (speed_sat == '0) ? (STEP_UNIT >> 1) : (STEP_UNIT * DATA_W'(speed_sat));

    // Palette memories
    logic [DATA_W-1:0] cur_mem [NCOMP];
    logic [DATA_W-1:0] tgt_mem [NCOMP];
    logic [DATA_W-1:0] cur_rdata_reg;
    logic [DATA_W-1:0] tgt_rdata_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              cur_we;
    logic              tgt_we;

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[wr_addr] <= wr_data;
        end
        cur_rdata_reg <= cur_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[wr_addr] <= wr_data;
        end
        tgt_rdata_reg <= tgt_mem[rd_addr];
    end

    // Sequencer and result registers
    state_t            state_reg, state_next;
    logic [NCW-1:0]    rd_idx_reg, rd_idx_next;
    logic [AW-1:0]     wb_idx_reg, wb_idx_next;
    logic [NCW-1:0]    left_reg, left_next;
    logic [NCW-1:0]    unfinished_reg, unfinished_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              result_valid_reg, result_valid_next;
    logic [DATA_W-1:0] read_value_reg, read_value_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_idx_reg       <= '0;
            wb_idx_reg       <= '0;
            left_reg         <= '0;
            unfinished_reg   <= NCW'(NCOMP);
            rd_ok_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_idx_reg       <= rd_idx_next;
            wb_idx_reg       <= wb_idx_next;
            left_reg         <= left_next;
            unfinished_reg   <= unfinished_next;
            rd_ok_reg        <= rd_ok_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
    end

    // Per-component fade update on the memory read data
    logic [DATA_W-1:0] tgt_eff;
    logic              above;
    logic [DATA_W-1:0] delta;
    logic              far;
    logic [DATA_W-1:0] faded;

    always_comb
    begin
        priority if (target_source_reg == SRC_BLACK)
            tgt_eff = BLACK_LEVEL;
        else if (target_source_reg == SRC_WHITE)
            tgt_eff = WHITE_LEVEL;
        else
            tgt_eff = tgt_rdata_reg;
    end

    assign above = cur_rdata_reg > tgt_eff;
    assign delta = above ? (cur_rdata_reg - tgt_eff) : (tgt_eff - cur_rdata_reg);
    assign far   = delta > step;
    assign faded = far ? (above ? (cur_rdata_reg - step) : (cur_rdata_reg + step)) : tgt_eff;

    logic           accept;
    logic           entry_ok;
    logic [NCW-1:0] left_inc;

    assign accept   = start && (state_reg == ST_IDLE);
    assign entry_ok = entry < ENTRY_W'(n_comp);
    assign left_inc = left_reg + NCW'(far);

    // Next state, memory control and results
    always_comb
    begin
        state_next        = state_reg;
        rd_idx_next       = rd_idx_reg;
        wb_idx_next       = wb_idx_reg;
        left_next         = left_reg;
        unfinished_next   = unfinished_reg;
        rd_ok_next        = rd_ok_reg;
        result_valid_next = 1'b0;
        read_value_next   = '0;
        rd_addr           = entry[AW-1:0];
        wr_addr           = entry[AW-1:0];
        wr_data           = value;
        cur_we            = 1'b0;
        tgt_we            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_WR_CUR:
                        begin
                            cur_we            = entry_ok;
                            result_valid_next = 1'b1;
                        end
                        MODE_WR_TGT:
                        begin
                            tgt_we            = entry_ok;
                            result_valid_next = 1'b1;
                        end
                        MODE_TICK:
                        begin
                            // first component read goes out now
                            rd_addr     = '0;
                            rd_idx_next = NCW'(1);
                            wb_idx_next = '0;
                            left_next   = '0;
                            state_next  = ST_TICK;
                        end
                        MODE_RD_CUR:
                        begin
                            rd_ok_next = entry_ok;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end

            ST_READ:
            begin
                result_valid_next = 1'b1;
                read_value_next   = rd_ok_reg ? cur_rdata_reg : '0;
                state_next        = ST_IDLE;
            end

            ST_TICK:
            begin
                // write back the component read last cycle, read the next one
                cur_we    = 1'b1;
                wr_addr   = wb_idx_reg;
                wr_data   = faded;
                rd_addr   = rd_idx_reg[AW-1:0];
                left_next = left_inc;
                if (rd_idx_reg == n_comp)
                begin
                    unfinished_next   = left_inc;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    wb_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next = rd_idx_reg + NCW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign read_value   = read_value_reg;
    assign remaining    = REMAIN_W'(unfinished_reg);
    assign done_res     = (unfinished_reg == '0);

    // Checks
    a_tick_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_TICK) |=> (busy && !result_valid))
        else $error("fade tick did not enter the sweep");

    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_WR_CUR || mode == MODE_WR_TGT)) |=> result_valid)
        else $error("write transfer gave no result");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_RD_CUR) |=> (!result_valid ##1 result_valid))
        else $error("read transfer result timing wrong");

    a_sweep_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK) |-> (rd_idx_reg <= n_comp && left_reg < rd_idx_reg))
        else $error("sweep index or unfinished count out of range");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && rd_idx_reg == n_comp) |=> (result_valid && !busy))
        else $error("sweep end without result");

endmodule
